// ===== rtl/fp32_compare_classify_sign_unit_defines.svh =====
// Assertion macros for the single-precision compare unit.
`ifndef FP32_COMPARE_CLASSIFY_SIGN_UNIT_DEFINES_SVH
`define FP32_COMPARE_CLASSIFY_SIGN_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define FCCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define FCCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fccs_pkg.sv =====
package fccs_pkg;

  typedef enum logic [3:0] {
    KIND_SGNJ    = 4'd0,
    KIND_SGNJN   = 4'd1,
    KIND_SGNJX   = 4'd2,
    KIND_MIN     = 4'd3,
    KIND_MAX     = 4'd4,
    KIND_EQ      = 4'd5,
    KIND_LT      = 4'd6,
    KIND_LE      = 4'd7,
    KIND_CLASS   = 4'd8,
    KIND_MV_F2I  = 4'd9,
    KIND_MV_I2F  = 4'd10
  } kind_e;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [31:0] BoxHigh  = 32'hFFFF_FFFF;

  // Kind kept as raw bits: codes 11 to 15 must pass as a no-op.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] first_operand;
    logic [31:0] second_operand;
  } req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        to_integer_reg;
    logic        invalid_flag;
  } res_t;

endpackage

// ===== rtl/fp32_compare_classify_sign_unit.sv =====
// Channel   Direction  Handshake            Payload
// command   in         start && !busy       in_i     (fccs_pkg::req_t)
// result    out        done_o, one cycle    result_o (fccs_pkg::res_t)
//
// An accepted command passes through the operand register, then through the
// compare/classify logic into the result register, which drives done_o.
// A new transaction may be taken every cycle; busy stays low.
// Reset clears only the two valid flags; payload registers are not reset.
// The receiver cannot stall, so nothing is ever held back.
`include "fp32_compare_classify_sign_unit_defines.svh"

module fp32_compare_classify_sign_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  fccs_pkg::req_t in_i,
  output logic           done_o,
  output fccs_pkg::res_t result_o
);

  logic           accept;
  logic           req_valid_q;
  fccs_pkg::req_t req_q;
  fccs_pkg::res_t res_d;
  logic           res_valid_q;
  fccs_pkg::res_t res_q;
  logic [32:0]    res_top;
  logic           float_nz;
  logic           int_hi;

  // Fully pipelined, never refuses a command.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Control flags: operand stage valid and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      req_valid_q <= accept;
      res_valid_q <= req_valid_q;
    end
  end

  // Operand register, loaded only on a transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_i;
    end
  end

  // All the operation logic sits here, between the two registers.
  fccs_datapath u_datapath (
    .req_i (req_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = res_valid_q;
  assign result_o = res_q;

  // Upper half plus the low word's sign bit, for the boxing and extension checks.
  assign res_top  = result_o.result_value[63:31];
  assign float_nz = done_o && !result_o.to_integer_reg && (result_o.result_value != 64'd0);
  assign int_hi   = done_o && result_o.to_integer_reg && (res_top[32:1] != 32'd0);

  // Every accepted transaction yields its result strobe on done_o.
  `FCCS_ASSERT_IMP(a_latency, clk_i, rst_ni, accept, ##2 done_o, "result strobe missing")
  // A strobe only follows a filled operand stage.
  `FCCS_ASSERT_NXT(a_no_spurious, clk_i, rst_ni, !req_valid_q, !done_o, "spurious result")
  // Non-zero float results are NaN-boxed.
  `FCCS_ASSERT_IMP(a_boxed, clk_i, rst_ni, float_nz, &res_top[32:1], "float result not boxed")
  // Integer results have an all-zero or all-one upper half.
  `FCCS_ASSERT_IMP(a_sext, clk_i, rst_ni, int_hi, &res_top, "integer result not sign-extended")

endmodule

// ===== rtl/fccs_datapath.sv =====
module fccs_datapath (
  input  fccs_pkg::req_t req_i,
  output fccs_pkg::res_t res_o
);

  logic [31:0] a, b;
  logic        nan_a, nan_b, snan_a, snan_b, any_nan, any_snan;
  logic        zero_both;
  logic [31:0] key_a, key_b;
  logic        key_lt, key_gt, lt_ab, eq_ab;
  logic [31:0] min_val, max_val;
  logic [9:0]  class_mask;
  logic [7:0]  exp_a;
  logic [22:0] man_a;

  assign a = req_i.first_operand;
  assign b = req_i.second_operand;

  assign nan_a    = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  assign nan_b    = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  assign snan_a   = nan_a && !a[22];
  assign snan_b   = nan_b && !b[22];
  assign any_nan  = nan_a || nan_b;
  assign any_snan = snan_a || snan_b;

  assign zero_both = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);

  // monotone unsigned key, -0 just below +0
  assign key_a = a[31] ? ~a : {1'b1, a[30:0]};
  assign key_b = b[31] ? ~b : {1'b1, b[30:0]};
  assign key_lt = key_a < key_b;
  assign key_gt = key_a > key_b;

  assign lt_ab = !zero_both && key_lt;
  assign eq_ab = (a == b) || zero_both;

  always_comb begin
    priority if (nan_a && nan_b) begin
      min_val = fccs_pkg::CanonNan;
      max_val = fccs_pkg::CanonNan;
    end else if (nan_a) begin
      min_val = b;
      max_val = b;
    end else if (nan_b) begin
      min_val = a;
      max_val = a;
    end else if (zero_both) begin
      min_val = a[31] ? a : b;
      max_val = a[31] ? b : a;
    end else begin
      min_val = key_lt ? a : b;
      max_val = key_gt ? a : b;
    end
  end

  assign exp_a = a[30:23];
  assign man_a = a[22:0];

  always_comb begin
    class_mask = '0;
    priority if (exp_a == 8'hFF) begin
      if (man_a == 23'd0) begin
        class_mask[a[31] ? 4'd0 : 4'd7] = 1'b1;
      end else begin
        class_mask[a[22] ? 4'd9 : 4'd8] = 1'b1;
      end
    end else if (exp_a == 8'h00) begin
      if (man_a == 23'd0) begin
        class_mask[a[31] ? 4'd3 : 4'd4] = 1'b1;
      end else begin
        class_mask[a[31] ? 4'd2 : 4'd5] = 1'b1;
      end
    end else begin
      class_mask[a[31] ? 4'd1 : 4'd6] = 1'b1;
    end
  end

  always_comb begin
    res_o = '0;
    unique case (req_i.kind)
      fccs_pkg::KIND_SGNJ: begin
        res_o.result_value = {fccs_pkg::BoxHigh, b[31], a[30:0]};
      end
      fccs_pkg::KIND_SGNJN: begin
        res_o.result_value = {fccs_pkg::BoxHigh, ~b[31], a[30:0]};
      end
      fccs_pkg::KIND_SGNJX: begin
        res_o.result_value = {fccs_pkg::BoxHigh, a[31] ^ b[31], a[30:0]};
      end
      fccs_pkg::KIND_MIN: begin
        res_o.result_value = {fccs_pkg::BoxHigh, min_val};
        res_o.invalid_flag = any_snan;
      end
      fccs_pkg::KIND_MAX: begin
        res_o.result_value = {fccs_pkg::BoxHigh, max_val};
        res_o.invalid_flag = any_snan;
      end
      fccs_pkg::KIND_EQ: begin
        res_o.to_integer_reg = 1'b1;
        res_o.result_value   = {63'd0, !any_nan && eq_ab};
        res_o.invalid_flag   = any_snan;
      end
      fccs_pkg::KIND_LT: begin
        res_o.to_integer_reg = 1'b1;
        res_o.result_value   = {63'd0, !any_nan && lt_ab};
        res_o.invalid_flag   = any_nan;
      end
      fccs_pkg::KIND_LE: begin
        res_o.to_integer_reg = 1'b1;
        res_o.result_value   = {63'd0, !any_nan && (lt_ab || eq_ab)};
        res_o.invalid_flag   = any_nan;
      end
      fccs_pkg::KIND_CLASS: begin
        res_o.to_integer_reg = 1'b1;
        res_o.result_value   = {54'd0, class_mask};
      end
      fccs_pkg::KIND_MV_F2I: begin
        res_o.to_integer_reg = 1'b1;
        res_o.result_value   = {{32{a[31]}}, a};
      end
      fccs_pkg::KIND_MV_I2F: begin
        res_o.result_value = {fccs_pkg::BoxHigh, a};
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

// ===== test/fp32_compare_classify_sign_unit_tb.sv =====
module fp32_compare_classify_sign_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fccs_pkg::*;

  // Bit positions in the one-hot classify mask
  localparam int ClsNegInf  = 0;
  localparam int ClsNegNorm = 1;
  localparam int ClsNegSub  = 2;
  localparam int ClsNegZero = 3;
  localparam int ClsPosZero = 4;
  localparam int ClsPosSub  = 5;
  localparam int ClsPosNorm = 6;
  localparam int ClsPosInf  = 7;
  localparam int ClsSNan    = 8;
  localparam int ClsQNan    = 9;

  localparam logic [31:0] SignBit = 32'h8000_0000;
  localparam logic [7:0]  ExpOnes = 8'hFF;

  // Hard stop well beyond the slowest legal run (~600 transactions)
  localparam int unsigned RunLimitNs = 2_000_000;
  localparam int unsigned RandomItems = 550;

  // Tracks expected results in order of acceptance and checks the block against them.
  class fp_result_scoreboard;
    res_t        expected_q[$];
    int unsigned mismatches;
    int unsigned accepted;
    int unsigned checked;
    int unsigned invalid_seen;
    int unsigned noops;

    static function bit is_nan(logic [31:0] x);
      return (x[30:23] == ExpOnes) && (x[22:0] != '0);
    endfunction

    static function bit is_snan(logic [31:0] x);
      // quiet bit is the top mantissa bit
      return is_nan(x) && !x[22];
    endfunction

    function res_t predict(req_t req);
      logic [31:0] a, b, key_a, key_b, pick;
      bit          nan_a, nan_b, any_snan, both_zero, a_lt_b, b_lt_a, a_eq_b;
      int          cls;
      res_t        r;
      a         = req.first_operand;
      b         = req.second_operand;
      r         = '0;
      nan_a     = is_nan(a);
      nan_b     = is_nan(b);
      any_snan  = is_snan(a) || is_snan(b);
      both_zero = (a[30:0] == '0) && (b[30:0] == '0);
      // monotone integer keys: negatives inverted, positives offset above them
      key_a     = a[31] ? ~a : (a | SignBit);
      key_b     = b[31] ? ~b : (b | SignBit);
      a_lt_b    = !both_zero && (key_a < key_b);
      b_lt_a    = !both_zero && (key_b < key_a);
      a_eq_b    = (a == b) || both_zero;
      case (req.kind)
        KIND_SGNJ:  r.result_value = {BoxHigh, b[31], a[30:0]};
        KIND_SGNJN: r.result_value = {BoxHigh, ~b[31], a[30:0]};
        KIND_SGNJX: r.result_value = {BoxHigh, a[31] ^ b[31], a[30:0]};
        KIND_MIN, KIND_MAX: begin
          if (nan_a && nan_b) pick = CanonNan;
          else if (nan_a) pick = b;
          else if (nan_b) pick = a;
          else if (both_zero) begin
            // -0 sits below +0
            if (req.kind == KIND_MAX) pick = a[31] ? b : a;
            else pick = a[31] ? a : b;
          end else if (req.kind == KIND_MAX) pick = b_lt_a ? a : b;
          else pick = a_lt_b ? a : b;
          r.result_value = {BoxHigh, pick};
          r.invalid_flag = any_snan;
        end
        KIND_EQ: begin
          r.to_integer_reg  = 1'b1;
          r.result_value[0] = !nan_a && !nan_b && a_eq_b;
          r.invalid_flag    = any_snan;
        end
        KIND_LT, KIND_LE: begin
          r.to_integer_reg = 1'b1;
          if (nan_a || nan_b) r.invalid_flag = 1'b1;
          else if (req.kind == KIND_LT) r.result_value[0] = a_lt_b;
          else r.result_value[0] = a_lt_b || a_eq_b;
        end
        KIND_CLASS: begin
          if (a[30:23] == ExpOnes) begin
            if (a[22:0] == '0) cls = a[31] ? ClsNegInf : ClsPosInf;
            else cls = a[22] ? ClsQNan : ClsSNan;
          end else if (a[30:23] == '0) begin
            if (a[22:0] == '0) cls = a[31] ? ClsNegZero : ClsPosZero;
            else cls = a[31] ? ClsNegSub : ClsPosSub;
          end else begin
            cls = a[31] ? ClsNegNorm : ClsPosNorm;
          end
          r.to_integer_reg = 1'b1;
          r.result_value   = 64'd1 << cls;
        end
        KIND_MV_F2I: begin
          r.to_integer_reg = 1'b1;
          r.result_value   = {{32{a[31]}}, a};
        end
        KIND_MV_I2F: r.result_value = {BoxHigh, a};
        default: ; // unused codes: all-zero no-op
      endcase
      return r;
    endfunction

    function void report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function void note_input(req_t req);
      accepted++;
      if (req.kind > KIND_MV_I2F) noops++;
      expected_q.push_back(predict(req));
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result value=%h", got.result_value));
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.invalid_flag) invalid_seen++;
      if (got.result_value !== exp.result_value)
        report($sformatf("result_value got %h exp %h", got.result_value, exp.result_value));
      if (got.to_integer_reg !== exp.to_integer_reg)
        report($sformatf("to_integer_reg got %b exp %b", got.to_integer_reg,
                         exp.to_integer_reg));
      if (got.invalid_flag !== exp.invalid_flag)
        report($sformatf("invalid_flag got %b exp %b", got.invalid_flag, exp.invalid_flag));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t in_i   = '0;
  logic done_o;
  res_t result_o;

  fp_result_scoreboard sb = new();

  fp32_compare_classify_sign_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: everything is sampled on the rising edge, before the driver's NBAs land.
  // A result leaving and a command entering in the same cycle are independent, since
  // the result always belongs to an earlier transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(result_o);
      if (start && !busy) sb.note_input(in_i);
    end
  end

  // Present one command after a gap of idle cycles and hold it until accepted.
  // start is only lowered when a gap follows, so it never sees two NBAs in one step.
  task automatic send_cmd(logic [3:0] kind, logic [31:0] a, logic [31:0] b,
                          int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= '{kind: kind, first_operand: a, second_operand: b};
    do @(posedge clk_i); while (busy);
  endtask

  // Let the pipeline empty out completely before carrying on. One edge passes first,
  // so the last accepted transaction is already noted and start is never driven twice
  // in the same step.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Operand generator biased towards the awkward encodings; `other` lets the second
  // operand repeat or mirror the first so equality and signed-zero paths get hit.
  function automatic logic [31:0] rand_operand(logic [31:0] other);
    logic sgn;
    sgn = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       return {sgn, 31'd0};
      1:       return {sgn, 8'h00, 23'($urandom_range(1, 23'h7F_FFFF))};
      2, 3:    return {sgn, 8'($urandom_range(1, 254)), 23'($urandom)};
      4:       return {sgn, ExpOnes, 23'd0};
      5:       return {sgn, ExpOnes, 1'b1, 22'($urandom)};
      6:       return {sgn, ExpOnes, 1'b0, 22'($urandom_range(1, 22'h3F_FFFF))};
      7:       return other;
      8:       return other ^ SignBit;
      default: return $urandom;
    endcase
  endfunction

  // Global watchdog
  initial begin
    #(RunLimitNs);
    $display("watchdog expired with %0d results outstanding", sb.pending());
    $display("fp32_compare_classify_sign_unit verification failed");
    $finish;
  end

  initial begin
    logic [3:0]  kind;
    logic [31:0] a, b;
    int unsigned gap;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed corners ---
    // sign injection leaves a NaN payload alone and never flags
    send_cmd(KIND_SGNJ,  32'h7FC1_2345, 32'hBF80_0000, 0);
    send_cmd(KIND_SGNJN, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    send_cmd(KIND_SGNJX, 32'hFF80_0000, 32'hBF80_0000, 1);
    // min/max: signed zeros, a single quiet NaN, two signalling NaNs
    send_cmd(KIND_MIN, 32'h0000_0000, 32'h8000_0000, 0);
    send_cmd(KIND_MAX, 32'h8000_0000, 32'h0000_0000, 2);
    send_cmd(KIND_MIN, 32'h7FC0_0000, 32'h3F80_0000, 0);
    send_cmd(KIND_MAX, 32'h7F80_0001, 32'hFFA0_0000, 0);
    // compares: +0 == -0, sNaN on eq, qNaN on lt, equal values on le
    send_cmd(KIND_EQ, 32'h0000_0000, 32'h8000_0000, 0);
    send_cmd(KIND_EQ, 32'h7F80_0001, 32'h3F80_0000, 3);
    send_cmd(KIND_LT, 32'h7FC0_0000, 32'h3F80_0000, 0);
    send_cmd(KIND_LE, 32'hBF80_0000, 32'hBF80_0000, 0);
    // one operand per classify bucket
    send_cmd(KIND_CLASS, 32'hFF80_0000, '0, 0);
    send_cmd(KIND_CLASS, 32'hC000_0000, '0, 0);
    send_cmd(KIND_CLASS, 32'h8000_0001, '0, 1);
    send_cmd(KIND_CLASS, 32'h8000_0000, '0, 0);
    send_cmd(KIND_CLASS, 32'h0000_0000, '0, 0);
    send_cmd(KIND_CLASS, 32'h007F_FFFF, '0, 0);
    send_cmd(KIND_CLASS, 32'h7F7F_FFFF, '0, 4);
    send_cmd(KIND_CLASS, 32'h7F80_0000, '0, 0);
    send_cmd(KIND_CLASS, 32'h7FBF_FFFF, '0, 0);
    send_cmd(KIND_CLASS, 32'hFFC0_0000, '0, 0);
    // moves: sign extension on the integer side, boxing on the float side
    send_cmd(KIND_MV_F2I, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_cmd(KIND_MV_I2F, 32'h1234_5678, 32'h0000_0000, 0);
    // unused opcode behaves as a no-op
    send_cmd(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    drain();

    // --- random traffic ---
    // idling changes every 40 transactions: back-to-back, full random, or sparse gaps
    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 99) < 4) kind = 4'($urandom_range(11, 15));
      else kind = 4'($urandom_range(0, 10));
      a = rand_operand($urandom);
      b = rand_operand(a);
      case ((i / 40) % 3)
        0:       gap = 0;
        1:       gap = $urandom_range(0, 18);
        default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      endcase
      if (i == RandomItems / 2) drain();
      send_cmd(kind, a, b, gap);
    end
    drain();
    repeat (4) @(posedge clk_i);

    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("run covered %0d transactions (%0d unused-opcode no-ops), %0d results checked",
             sb.accepted, sb.noops, sb.checked);
    $display("invalid flag raised on %0d results, %0d mismatches", sb.invalid_seen,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("fp32_compare_classify_sign_unit verification clean");
    end else begin
      $display("fp32_compare_classify_sign_unit verification failed");
    end
    $finish;
  end

endmodule
